// ----- src/ipd_pkg.sv -----
// Shared types and constants for the IMU packet deframer.
package ipd_pkg;

	// Frame bytes
	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_LO_K0 = 8'h53;
	localparam logic [7:0] TYPE_LO_K1 = 8'h7A;
	localparam logic [7:0] TYPE_HI    = 8'h31;

	// Minimum whole-word payload lengths and capture size in bytes
	localparam logic [7:0] NEED_K0     = 8'd22;
	localparam logic [7:0] NEED_K1     = 8'd28;
	localparam int         STORE_BYTES = 28;
	localparam int         POS_W       = $clog2(STORE_BYTES);

	// Packet kinds
	localparam logic KIND_SCALED = 1'b0;
	localparam logic KIND_RAW    = 1'b1;

	// Fixed-point scale factors (16 fraction bits)
	localparam logic signed [31:0] ACCEL_SCALE = 32'sd20;
	localparam logic signed [31:0] RATE_SCALE  = 32'sd1260;

	// Tick values that count as a wrap
	localparam logic [15:0] TICK_LOW  = 16'h0000;
	localparam logic [15:0] TICK_HIGH = 16'hFFFF;

	typedef logic [STORE_BYTES-1:0][7:0] capture_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic               packet_kind;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
		logic        [31:0] time_stamp;
		logic        [31:0] wrap_total;
	} sample_word_t;

	// Parser to formatter: a completed packet waiting to be formatted
	typedef struct packed {
		logic     done;
		logic     kind;
		capture_t bytes;
	} parse_done_t;

endpackage

// ----- src/ipd_stream_ifs.sv -----
// Valid/ready channel interfaces for the deframer's byte input and sample output.
interface ipd_rx_if;
	import ipd_pkg::*;
	logic     valid;
	logic     ready;
	rx_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ipd_sample_if;
	import ipd_pkg::*;
	logic         valid;
	logic         ready;
	sample_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/ipd_parser.sv -----
// Frame parser: sync/type/length hunting and payload byte capture.
module ipd_parser (
	input  logic                clk,
	input  logic                arst_n,
	ipd_rx_if.sink              rx,
	input  logic                take,
	output ipd_pkg::parse_done_t pend
);
	import ipd_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_TYPE_LO,
		PH_TYPE_HI,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_SWALLOW
	} phase_t;

	phase_t     phase_q;
	logic       kind_q;
	logic [7:0] len_q;
	logic [7:0] pos_q;
	logic       done_q;
	capture_t   bytes_q;

	logic       acc;
	logic [7:0] b;
	logic [7:0] len_round;
	logic [7:0] len_need;
	logic [7:0] pos_next;

	assign acc       = rx.valid && rx.ready;
	assign b         = rx.data.rx_byte;
	assign rx.ready  = !done_q || take;
	assign len_round = kind_q ? {b[7:2], 2'b00} : {b[7:1], 1'b0};
	assign len_need  = kind_q ? NEED_K1 : NEED_K0;
	assign pos_next  = pos_q + 8'd1;

	// Phase sequencer and packet-complete flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			kind_q  <= KIND_SCALED;
			len_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (take)
				done_q <= 1'b0;
			if (acc) begin
				case (phase_q)
					PH_SYNC1:
						phase_q <= (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
					PH_SYNC2:
						phase_q <= (b == SYNC_BYTE) ? PH_TYPE_LO : PH_SYNC1;
					PH_TYPE_LO: begin
						if (b == TYPE_LO_K0) begin
							kind_q  <= KIND_SCALED;
							phase_q <= PH_TYPE_HI;
						end else if (b == TYPE_LO_K1) begin
							kind_q  <= KIND_RAW;
							phase_q <= PH_TYPE_HI;
						end else begin
							phase_q <= PH_SWALLOW;
						end
					end
					PH_TYPE_HI:
						phase_q <= (b == TYPE_HI) ? PH_LENGTH : PH_SYNC1;
					PH_LENGTH: begin
						if (len_round < len_need) begin
							phase_q <= PH_SYNC1;
						end else begin
							len_q   <= len_round;
							pos_q   <= '0;
							phase_q <= PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						pos_q <= pos_next;
						if (pos_next >= len_q) begin
							phase_q <= PH_SYNC1;
							done_q  <= 1'b1;
						end
					end
					default:
						phase_q <= PH_SYNC1;
				endcase
			end
		end
	end

	// Payload capture; bytes past the store are counted only
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_PAYLOAD && pos_q < 8'(STORE_BYTES))
			bytes_q[pos_q[POS_W-1:0]] <= b;
	end

	assign pend.done  = done_q;
	assign pend.kind  = kind_q;
	assign pend.bytes = bytes_q;

endmodule

// ----- src/ipd_formatter.sv -----
// Sample formatter: scaling, word assembly, wrap count and output register.
module ipd_formatter (
	input  logic                clk,
	input  logic                arst_n,
	input  ipd_pkg::parse_done_t pend,
	output logic                take,
	ipd_sample_if.source        sample
);
	import ipd_pkg::*;

	logic         valid_q;
	logic [31:0]  wraps_q;
	sample_word_t data_q;

	logic [5:0][15:0]        half;
	logic [6:0][31:0]        word;
	logic signed [5:0][31:0] scaled;
	logic [15:0]             tick;
	logic                    is_wrap;
	logic [31:0]             wraps_next;
	sample_word_t            fmt;

	// Big-endian half words and little-endian 32-bit words
	always_comb begin
		for (int k = 0; k < 6; k++)
			half[k] = {pend.bytes[2*k], pend.bytes[2*k+1]};
		for (int k = 0; k < 7; k++)
			word[k] = {pend.bytes[4*k+3], pend.bytes[4*k+2],
				pend.bytes[4*k+1], pend.bytes[4*k]};
		for (int k = 0; k < 3; k++) begin
			scaled[k]   = 32'(signed'(half[k])) * ACCEL_SCALE;
			scaled[k+3] = 32'(signed'(half[k+3])) * RATE_SCALE;
		end
	end

	// Tick is half word ten (payload bytes 20 and 21); in scaled packets, count it when pinned at either end
	assign tick       = {pend.bytes[20], pend.bytes[21]};
	assign is_wrap    = (pend.kind == KIND_SCALED) &&
		(tick == TICK_LOW || tick == TICK_HIGH);
	assign wraps_next = wraps_q + 32'(is_wrap);

	always_comb begin
		fmt.packet_kind = pend.kind;
		fmt.wrap_total  = wraps_next;
		if (pend.kind == KIND_SCALED) begin
			fmt.accel_x    = scaled[0];
			fmt.accel_y    = scaled[1];
			fmt.accel_z    = scaled[2];
			fmt.rate_x     = scaled[3];
			fmt.rate_y     = scaled[4];
			fmt.rate_z     = scaled[5];
			fmt.time_stamp = {16'h0000, tick};
		end else begin
			fmt.accel_x    = word[1];
			fmt.accel_y    = word[2];
			fmt.accel_z    = word[3];
			fmt.rate_x     = word[4];
			fmt.rate_y     = word[5];
			fmt.rate_z     = word[6];
			fmt.time_stamp = word[0];
		end
	end

	assign take = pend.done && (!valid_q || sample.ready);

	// Output register and wrap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wraps_q <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			wraps_q <= wraps_next;
		end else if (sample.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			data_q <= fmt;
	end

	assign sample.valid = valid_q;
	assign sample.data  = data_q;

endmodule

// ----- src/imu_packet_deframer_core.sv -----
// Top level of the IMU packet deframer: parser and sample formatter.
// Usage:
//   rx carries one serial byte per word; sample carries one decoded IMU
//   sample per complete packet (kind, three accel, three rate, time stamp,
//   running wrap count). Both are valid/ready channels.
//   Frames are 0x55 0x55, a type pair, a length byte and the payload.
//   Throughput: one byte per cycle while rx.ready is high; header and payload
//   bytes stream back to back with no gaps.
//   Path: the last payload byte lands in the capture registers and sets
//   the packet-complete flag; the packet then passes through the scaling
//   multiplies into the output register once that register is free.
//   Stall: a finished sample waits in the output register while bytes
//   keep flowing; rx.ready drops only when a second packet completes
//   while the first sample is still not taken, and rises again on the
//   cycle that sample is taken.
//   Reset: the parser returns to hunting for the first sync byte, the
//   output register empties and the wrap count clears. The capture
//   store is not cleared; every byte a sample uses is written first.
module imu_packet_deframer_core (
	input  logic         clk,
	input  logic         arst_n,
	ipd_rx_if.sink       rx,
	ipd_sample_if.source sample
);
	import ipd_pkg::*;

	parse_done_t pend;
	logic        take;

	ipd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.pend   (pend)
	);

	ipd_formatter u_formatter (
		.clk    (clk),
		.arst_n (arst_n),
		.pend   (pend),
		.take   (take),
		.sample (sample)
	);

	// Input stalls only behind a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (pend.done && sample.valid && !sample.ready))
		else $error("rx stalled without a blocked sample");

	// A pending packet moved on appears as a sample next cycle
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> sample.valid)
		else $error("formatted packet did not reach the output");

	// Scaled kind time stamps are 16-bit ticks
	a_tick_width: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.data.packet_kind == KIND_SCALED)
		|-> (sample.data.time_stamp[31:16] == 16'h0000))
		else $error("scaled sample time stamp exceeds 16 bits");

	// Wrap count moves by at most one per sample taken
	a_wrap_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sample.valid) |=>
		((sample.data.wrap_total == $past(sample.data.wrap_total)) ||
		(sample.data.wrap_total == $past(sample.data.wrap_total) + 32'd1)))
		else $error("wrap count jumped");

endmodule
